@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset
`define AST_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset
`define AST_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define AST_PROP(lbl, clk, rst_n, prop)
`define AST_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ hdl/swsr_pkg.sv @@
// ----------------------------------------------------------------------------
// swsr_pkg
// Shared constants, codes and controller/datapath interface types for the
// tag stack with search and remove.
// ----------------------------------------------------------------------------
package swsr_pkg;

    // Stack geometry
    localparam int DEPTH   = 16;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Field widths
    localparam int TAG_W       = 32;
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 2;
    localparam int POS_W       = 5;
    localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;

    typedef logic signed [TAG_W-1:0] t_tag;
    typedef logic [ACT_W-1:0]        t_action;
    typedef logic [STAT_W-1:0]       t_status;
    typedef logic [POS_W-1:0]        t_pos;
    typedef logic [FILL_W-1:0]       t_fill;
    typedef logic [ADDR_W-1:0]       t_addr;

    // Request codes
    localparam t_action ACT_PUSH   = 2'd0;
    localparam t_action ACT_REMOVE = 2'd1;
    localparam t_action ACT_FIND   = 2'd2;

    // Result status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

    // Full-stack fill level
    localparam t_fill FILL_MAX = FILL_W'(DEPTH);

    // Controller to datapath commands
    typedef struct packed {
        logic    load_req;     // capture the accepted request
        logic    do_push;      // write tag on top, bump fill
        logic    scan_start;   // arm the top-down search
        logic    scan_en;      // search step
        logic    shift_start;  // arm the gap close above the match
        logic    shift_en;     // gap close step
        logic    dec_fill;     // drop fill by one
        logic    out_load;     // load the result register
        t_status res_status;   // status for the result
        logic    res_pos_en;   // result carries the match position
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_action action;       // captured request code
        logic    full;         // stack holds DEPTH entries
        logic    hit;          // current compare matches the tag
        logic    scan_done;    // search ran out of entries
        logic    shift_done;   // gap close finished
        logic    out_vld;      // result register occupied
        t_fill   fill;         // number of valid entries
    } t_dp_sts;

endpackage

@@ hdl/stack_with_search_and_remove.sv @@
// ----------------------------------------------------------------------------
// stack_with_search_and_remove
// Bounded LIFO stack of 32-bit tags with push, remove-by-value and find.
// ----------------------------------------------------------------------------
// One request is worked at a time and every request yields exactly one
// result transaction. Action (tuser) 0 pushes the tag, 1 removes the topmost
// entry equal to the tag (entries above close the gap in order), 2 finds the
// topmost match and reports its 1-based position from the top; code 3 is
// ignored and answers ok. Entries live in a single RAM with one write and one
// registered read port, so the search reads one entry per cycle from the top
// and the gap close moves one entry per cycle. The longest request is removing
// the bottom entry of a full stack. The result is presented in the cycle the
// block turns ready again. The next request is taken as soon as the block is
// back to idle, even while the previous result still waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stack_with_search_and_remove (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request: tdata = tag[31:0]; tuser = action[1:0]
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [swsr_pkg::TAG_W-1:0]    i_s_axis_tdata,
    input  logic [swsr_pkg::ACT_W-1:0]    i_s_axis_tuser,
    // result: tdata = position[4:0], zero[7:5]; tuser = status[1:0]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [swsr_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [swsr_pkg::STAT_W-1:0]   o_m_axis_tuser
);
    import swsr_pkg::*;

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;
    t_status out_status;
    t_pos    out_pos;

    swsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (s_sts),
        .o_cmd       (s_cmd)
    );

    swsr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (t_tag'(i_s_axis_tdata)),
        .i_action     (i_s_axis_tuser),
        .i_out_ready  (i_m_axis_tready),
        .i_cmd        (s_cmd),
        .o_sts        (s_sts),
        .o_out_vld    (o_m_axis_tvalid),
        .o_out_status (out_status),
        .o_out_pos    (out_pos)
    );

    assign o_m_axis_tuser = out_status;
    assign o_m_axis_tdata = {{(OUT_TDATA_W - POS_W){1'b0}}, out_pos};

    // Checks
    `AST_NEVER(a_fill_bound, i_clk, i_rst_n, s_sts.fill > FILL_MAX)
    `AST_NEVER(a_one_writer, i_clk, i_rst_n, s_cmd.do_push && s_cmd.shift_en)
    `AST_PROP(a_out_slot_free, i_clk, i_rst_n, s_cmd.out_load |-> (!s_sts.out_vld || i_m_axis_tready))
    `AST_PROP(a_one_in_flight, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)

endmodule

@@ hdl/swsr_ram.sv @@
// ----------------------------------------------------------------------------
// swsr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swsr_ram #(
    parameter int DATA_W = 32,
    parameter int WORDS  = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]                        i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]                        o_rd_data
);

    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/swsr_dp.sv @@
// ----------------------------------------------------------------------------
// swsr_dp
// Datapath: request capture, fill count, entry RAM, top-down search
// pipeline, gap-close shifter and the result register.
// ----------------------------------------------------------------------------
module swsr_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swsr_pkg::t_tag        i_tag,
    input  swsr_pkg::t_action     i_action,
    input  logic                  i_out_ready,
    input  swsr_pkg::t_dp_cmd     i_cmd,
    output swsr_pkg::t_dp_sts     o_sts,
    output logic                  o_out_vld,
    output swsr_pkg::t_status     o_out_status,
    output swsr_pkg::t_pos        o_out_pos
);
    import swsr_pkg::*;

    t_tag    r_tag;
    t_action r_act;
    t_fill   r_fill;

    // search state
    t_fill   r_rd_ptr;
    logic    r_cmp_vld;
    t_addr   r_cmp_idx;
    t_pos    r_pos;

    // shift state
    t_fill   r_sh_rd;
    logic    r_sh_pend;
    t_addr   r_sh_wa;

    // result register
    logic    r_out_vld;
    t_status r_out_status;
    t_pos    r_out_pos;

    t_tag    rd_data;
    t_fill   rd_ptr_m1;
    t_fill   sh_rd_m1;
    t_fill   match_dist;
    logic    scan_more;
    logic    sh_more;
    logic    hit;
    logic    ram_we;
    t_addr   ram_wa;
    t_tag    ram_wd;
    logic    ram_re;
    t_addr   ram_ra;

    assign rd_ptr_m1  = r_rd_ptr - FILL_W'(1);
    assign sh_rd_m1   = r_sh_rd - FILL_W'(1);
    assign match_dist = r_fill - FILL_W'(r_cmp_idx);
    assign scan_more  = (r_rd_ptr != '0);
    assign sh_more    = (r_sh_rd < r_fill);
    assign hit        = r_cmp_vld && (rd_data == r_tag);

    // RAM port steering: push or gap-close write, search or shift read
    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_fill[ADDR_W-1:0];
        ram_wd = r_tag;
        if (i_cmd.do_push) begin
            ram_we = 1'b1;
        end else if (i_cmd.shift_en && r_sh_pend) begin
            ram_we = 1'b1;
            ram_wa = r_sh_wa;
            ram_wd = rd_data;
        end
        if (i_cmd.shift_en) begin
            ram_re = sh_more;
            ram_ra = r_sh_rd[ADDR_W-1:0];
        end else begin
            ram_re = i_cmd.scan_en && scan_more;
            ram_ra = rd_ptr_m1[ADDR_W-1:0];
        end
    end

    swsr_ram #(
        .DATA_W (TAG_W),
        .WORDS  (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (rd_data)
    );

    // Request capture and match position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_tag <= i_tag;
            r_act <= i_action;
        end
        if (i_cmd.scan_en && hit) begin
            r_pos <= POS_W'(match_dist);
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.do_push) begin
            r_fill <= r_fill + FILL_W'(1);
        end else if (i_cmd.dec_fill) begin
            r_fill <= r_fill - FILL_W'(1);
        end
    end

    // Search pipeline: issue read of next lower entry, compare previous one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan_en) begin
            r_cmp_vld <= scan_more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rd_ptr <= r_fill;
        end else if (i_cmd.scan_en && scan_more) begin
            r_rd_ptr  <= rd_ptr_m1;
            r_cmp_idx <= rd_ptr_m1[ADDR_W-1:0];
        end
    end

    // Gap close: read entry k+1, write it to k in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_pend <= 1'b0;
        end else if (i_cmd.shift_start) begin
            r_sh_pend <= 1'b0;
        end else if (i_cmd.shift_en) begin
            r_sh_pend <= sh_more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_start) begin
            r_sh_rd <= FILL_W'(r_cmp_idx) + FILL_W'(1);
        end else if (i_cmd.shift_en && sh_more) begin
            r_sh_rd <= r_sh_rd + FILL_W'(1);
            r_sh_wa <= sh_rd_m1[ADDR_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.res_status;
            r_out_pos    <= i_cmd.res_pos_en ? r_pos : '0;
        end
    end

    // Status back to the controller
    always_comb begin
        o_sts.action     = r_act;
        o_sts.full       = (r_fill >= FILL_MAX);
        o_sts.hit        = hit;
        o_sts.scan_done  = !scan_more && !r_cmp_vld;
        o_sts.shift_done = !sh_more && !r_sh_pend;
        o_sts.out_vld    = r_out_vld;
        o_sts.fill       = r_fill;
    end

    assign o_out_vld    = r_out_vld;
    assign o_out_status = r_out_status;
    assign o_out_pos    = r_out_pos;

endmodule

@@ hdl/swsr_ctrl.sv @@
// ----------------------------------------------------------------------------
// swsr_ctrl
// Controller: sequences one request at a time through decode, search,
// gap close and hand-off to the result register.
// ----------------------------------------------------------------------------
module swsr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    input  swsr_pkg::t_dp_sts     i_sts,
    output swsr_pkg::t_dp_cmd     o_cmd
);
    import swsr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state, n_state;
    t_status    r_status, n_status;
    logic       r_pos_en, n_pos_en;
    logic       out_free;

    assign out_free = !i_sts.out_vld || i_out_ready;

    // State and result bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_pos_en <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_pos_en <= n_pos_en;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        n_status         = r_status;
        n_pos_en         = r_pos_en;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.res_status = r_status;
        o_cmd.res_pos_en = r_pos_en;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_status       = ST_OK;
                    n_pos_en       = 1'b0;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.action) inside
                    ACT_PUSH: begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_cmd.do_push = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    ACT_REMOVE, ACT_FIND: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.hit) begin
                    if (i_sts.action == ACT_FIND) begin
                        n_pos_en = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.shift_start = 1'b1;
                        n_state           = S_SHIFT;
                    end
                end else if (i_sts.scan_done) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_en = 1'b1;
                if (i_sts.shift_done) begin
                    o_cmd.dec_fill = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ tb/sv/tag_stack_checker.sv @@
// ----------------------------------------------------------------------------
// tag_stack_checker
// Watches the request and result streams of the tag stack, keeps its own
// copy of the stack contents, works out the status and match position of
// every accepted request and compares each result transaction in order.
// ----------------------------------------------------------------------------
module tag_stack_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream as seen at the block
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    input  logic [swsr_pkg::TAG_W-1:0]       i_req_tag,      // tag[31:0]
    input  swsr_pkg::t_action                i_req_action,   // action[1:0]
    // result stream as seen at the block
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    input  logic [swsr_pkg::OUT_TDATA_W-1:0] i_res_data,     // position[4:0], zero[7:5]
    input  swsr_pkg::t_status                i_res_status,   // status[1:0]
    output int                               o_err_cnt,
    output int                               o_pending
);
    import swsr_pkg::*;

    typedef struct packed {
        t_status status;
        t_pos    pos;
    } t_stack_result;

    // Shadow stack, bottom at index 0
    logic [TAG_W-1:0] shadow_tags [DEPTH];
    int               shadow_fill;
    t_stack_result    pending_results [$];

    initial o_err_cnt = 0;
    assign o_pending = pending_results.size();

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        o_err_cnt++;
    endtask

    // Apply one request to the shadow stack and return its result
    function automatic t_stack_result apply_request(input t_action act,
                                                    input logic [TAG_W-1:0] tag);
        t_stack_result res;
        int            hit_idx;
        res.status = ST_OK;
        res.pos    = '0;
        hit_idx    = -1;
        // topmost match wins
        for (int i = shadow_fill - 1; i >= 0; i--) begin
            if (hit_idx < 0 && shadow_tags[i] == tag) begin
                hit_idx = i;
            end
        end
        case (act)
            ACT_PUSH: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_tags[shadow_fill] = tag;
                    shadow_fill++;
                end
            end
            ACT_REMOVE: begin
                if (hit_idx < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    // entries above the match slide down, order kept
                    for (int k = hit_idx; k + 1 < shadow_fill; k++) begin
                        shadow_tags[k] = shadow_tags[k+1];
                    end
                    shadow_fill--;
                end
            end
            ACT_FIND: begin
                if (hit_idx < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.pos = t_pos'(shadow_fill - hit_idx);
                end
            end
            default: ;  // unused code leaves the stack alone
        endcase
        return res;
    endfunction

    // Results are checked before requests so a result can never match a
    // request taken at the same edge
    always @(posedge i_clk) begin
        t_stack_result want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            pending_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result transaction with no request outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (i_res_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_res_status, want.status));
                    if (i_res_data[POS_W-1:0] !== want.pos)
                        report_mismatch($sformatf("position got %0d want %0d",
                                                  i_res_data[POS_W-1:0], want.pos));
                    if (i_res_data[OUT_TDATA_W-1:POS_W] !== '0)
                        report_mismatch($sformatf("tdata pad bits got %b",
                                                  i_res_data[OUT_TDATA_W-1:POS_W]));
                end
            end
            if (i_req_valid && i_req_ready) begin
                pending_results.push_back(apply_request(i_req_action, i_req_tag));
            end
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the tag stack: a directed pass over fill-to-full, duplicates,
// deepest search and misses, then phased random push/remove/find traffic on
// a small tag pool with random stalls on both streams and one long result
// back-pressure stretch. Checking is done by tag_stack_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import swsr_pkg::*;

    localparam t_action ACT_UNUSED = 2'd3;
    localparam int      N_RANDOM   = 1125;
    localparam int      MAX_GAP    = 18;
    localparam int      LONG_HOLD  = 300;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_valid   = 1'b0;
    logic [TAG_W-1:0]       s_tag     = '0;
    t_action                s_act     = ACT_PUSH;
    logic                   m_ready   = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;
    t_status                m_status;
    int                     err_cnt;
    int                     pending;
    int                     sent      = 0;

    // Tags reused often so removes and finds hit, extremes included
    logic [TAG_W-1:0] tag_pool [10] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                        32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0001,
                                        32'hDEAD_BEEF, 32'h5555_5555, 32'hAAAA_AAAA,
                                        32'h0000_0006};

    stack_with_search_and_remove u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tag),
        .i_s_axis_tuser  (s_act),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_status)
    );

    tag_stack_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_valid),
        .i_req_ready  (s_ready),
        .i_req_tag    (s_tag),
        .i_req_action (s_act),
        .i_res_valid  (m_valid),
        .i_res_ready  (m_ready),
        .i_res_data   (m_data),
        .i_res_status (m_status),
        .o_err_cnt    (err_cnt),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    initial begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // One request transaction; some stretches run with no gaps at all
    task automatic send_req(input t_action act, input logic [TAG_W-1:0] tag);
        int gap;
        gap = (((sent / 100) % 4) == 2) ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge clk);
            s_valid <= 1'b0;
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_tag   <= tag;
        s_act   <= act;
        do @(posedge clk); while (!s_ready);
        sent++;
    endtask

    // Result side: random stalls, quiet stretches, one long hold-off
    initial begin
        int taken;
        int gap;
        taken = 0;
        wait (rst_n);
        forever begin
            if (taken == 400) begin
                repeat (LONG_HOLD) begin
                    @(negedge clk);
                    m_ready <= 1'b0;
                end
            end
            gap = (((taken / 70) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP);
            repeat (gap) begin
                @(negedge clk);
                m_ready <= 1'b0;
            end
            @(negedge clk);
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_valid);
            taken++;
        end
    end

    // Request side and verdict
    initial begin
        int      phase;
        int      roll;
        int      push_pct;
        t_action act;
        logic [TAG_W-1:0] tag;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill to full with extremes and a duplicate
        send_req(ACT_PUSH, 32'h8000_0000);
        send_req(ACT_PUSH, 32'h7FFF_FFFF);
        send_req(ACT_PUSH, 32'h0000_0000);
        send_req(ACT_PUSH, 32'hFFFF_FFFF);
        send_req(ACT_PUSH, 32'h0000_0005);
        for (int i = 1; i <= 3; i++) send_req(ACT_PUSH, TAG_W'(i));
        send_req(ACT_PUSH, 32'h0000_0005);
        for (int i = 6; i <= 12; i++) send_req(ACT_PUSH, TAG_W'(i));
        // push on a full stack
        send_req(ACT_PUSH, 32'h1234_5678);
        // deepest find, miss, duplicate handling
        send_req(ACT_FIND, 32'h8000_0000);
        send_req(ACT_FIND, 32'h1234_5678);
        send_req(ACT_FIND, 32'h0000_0005);
        send_req(ACT_REMOVE, 32'h0000_0005);
        send_req(ACT_FIND, 32'h0000_0005);
        send_req(ACT_REMOVE, 32'h1234_5678);
        // bottom removal shifts everything above
        send_req(ACT_REMOVE, 32'h8000_0000);
        send_req(ACT_UNUSED, 32'hFFFF_FFFF);

        // random traffic, push-heavy / balanced / drain phases
        for (int n = 0; n < N_RANDOM; n++) begin
            phase    = (n / 60) % 3;
            push_pct = (phase == 0) ? 70 : (phase == 1) ? 45 : 20;
            roll     = $urandom_range(0, 99);
            if (roll < 3)
                act = ACT_UNUSED;
            else if (roll < 3 + push_pct)
                act = ACT_PUSH;
            else if ($urandom_range(0, 1) == 0)
                act = ACT_REMOVE;
            else
                act = ACT_FIND;
            if ($urandom_range(0, 3) == 0)
                tag = $urandom;
            else
                tag = tag_pool[$urandom_range(0, 9)];
            send_req(act, tag);
        end

        @(negedge clk);
        s_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);

        if (err_cnt == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
